/* design/uuidtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuidtp_pkg
// Shared types and constants for the UUID text parser.
// ----------------------------------------------------------------------------
package uuidtp_pkg;

    // One character of text as it enters the block.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char_item;

    // One parse result.
    typedef struct packed {
        logic        parse_ok;
        logic [63:0] id_upper;
        logic [63:0] id_lower;
    } t_result;

    // Character after classification by the front end.
    typedef struct packed {
        logic       is_space;
        logic       is_open;
        logic       is_close;
        logic       is_dash;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       last;
    } t_char_class;

    // Queue status between two stages.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    localparam logic [5:0] BODY_LEN = 6'd36;
    localparam logic [5:0] DASH_POS0 = 6'd8;
    localparam logic [5:0] DASH_POS1 = 6'd13;
    localparam logic [5:0] DASH_POS2 = 6'd18;
    localparam logic [5:0] DASH_POS3 = 6'd23;

endpackage

/* design/uuid_text_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_parser
// Streaming parser for UUID text, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_item (char_code, last_char) and raise push; the
//   item is taken at a clock edge where push is high and full is low.
//   last_char marks the final character of one text.
//   Result channel: one result per text, after its final character. While
//   empty is low, o_result shows parse_ok and the 128-bit value (zero on a
//   failed parse); raise pop to take it.
// Throughput: one character per cycle; the parse sequencer handles one queued
//   character each cycle, but holds a final character until the result
//   register is free.
// Result path: a final character passes through the queue; the sequencer
//   drains it from the queue and registers the result.
// Stalls: the character queue (FIFO_DEPTH entries) lets input continue
//   while a result waits; only a final character waits for a free result
//   register, and full rises once the queue fills behind it.
// Reset: synchronous, active low; clears the queue, the parse state and the
//   result valid flag, so the first item after reset starts a new text.
// ----------------------------------------------------------------------------
module uuid_text_parser #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  uuidtp_pkg::t_char_item  i_item,
    input  logic                    pop,
    output logic                    empty,
    output uuidtp_pkg::t_result     o_result
);

    uuidtp_pkg::t_char_class w_class_in;    // classified input character
    uuidtp_pkg::t_char_class w_class_q;     // head of the character queue
    uuidtp_pkg::t_q_status   w_q_status;
    logic                    w_q_wr;
    logic                    w_q_pop;

    // Front end: classify each character as it arrives.
    uuidtp_front u_front (
        .i_item  (i_item),
        .o_class (w_class_in)
    );

    assign full   = w_q_status.full;
    assign w_q_wr = push && !w_q_status.full;

    // Decoupling queue between classifier and sequencer.
    uuidtp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_class_in),
        .i_rd      (w_q_pop),
        .o_rd_data (w_class_q),
        .o_status  (w_q_status)
    );

    // Back end: parse sequencer and result register.
    uuidtp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_class   (w_class_q),
        .i_q_empty (w_q_status.empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

`ifndef SYNTH
    // the queue can never report full and empty together
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("character queue full and empty at once");

    // the sequencer only dequeues an entry that exists
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_status.empty)
        else $error("dequeue from empty character queue");

    // a final character always leaves a result behind
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_pop && w_class_q.last) |=> !empty)
        else $error("final character produced no result");

    // a failed parse reports a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.parse_ok) |-> (o_result.id_upper == 64'd0
            && o_result.id_lower == 64'd0))
        else $error("failed parse with nonzero value");
`endif

endmodule

/* design/uuidtp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuidtp_front
// Character classifier: whitespace, braces, dash, hex digit and its value.
// ----------------------------------------------------------------------------
module uuidtp_front (
    input  uuidtp_pkg::t_char_item  i_item,
    output uuidtp_pkg::t_char_class o_class
);

    logic [7:0] w_c;
    logic       w_digit;
    logic       w_lower;
    logic       w_upper;

    assign w_c     = i_item.char_code;
    assign w_digit = (w_c >= uuidtp_pkg::CHAR_0) && (w_c <= uuidtp_pkg::CHAR_9);
    assign w_lower = (w_c >= uuidtp_pkg::CHAR_LC_A) && (w_c <= uuidtp_pkg::CHAR_LC_F);
    assign w_upper = (w_c >= uuidtp_pkg::CHAR_UC_A) && (w_c <= uuidtp_pkg::CHAR_UC_F);

    always_comb begin
        o_class.is_space = (w_c == uuidtp_pkg::CHAR_SPACE)
                        || ((w_c >= uuidtp_pkg::CHAR_TAB) && (w_c <= uuidtp_pkg::CHAR_CR));
        o_class.is_open  = (w_c == uuidtp_pkg::CHAR_OPEN);
        o_class.is_close = (w_c == uuidtp_pkg::CHAR_CLOSE);
        o_class.is_dash  = (w_c == uuidtp_pkg::CHAR_DASH);
        o_class.is_hex   = w_digit || w_lower || w_upper;
        // letters: low nibble of 'a'/'A' is 1, so add 9 to get 10
        o_class.hex_val  = w_digit ? w_c[3:0] : (w_c[3:0] + uuidtp_pkg::HEX_ALPHA_OFS);
        o_class.last     = i_item.last_char;
    end

endmodule

/* design/uuidtp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuidtp_fifo
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module uuidtp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  uuidtp_pkg::t_char_class   i_wr_data,
    input  logic                      i_rd,
    output uuidtp_pkg::t_char_class   o_rd_data,
    output uuidtp_pkg::t_q_status     o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    uuidtp_pkg::t_char_class r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* design/uuidtp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuidtp_back
// Parse sequencer: tracks phase and body position, assembles the 128-bit
// value and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module uuidtp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  uuidtp_pkg::t_char_class   i_class,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output uuidtp_pkg::t_result       o_result
);

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    logic [1:0]   r_phase,  n_phase;
    logic         r_braced, n_braced;
    logic [5:0]   r_pos,    n_pos;
    logic         r_odd,    n_odd;
    logic [3:0]   r_pend,   n_pend;
    logic [127:0] r_id,     n_id;
    logic         r_failed, n_failed;

    logic                r_out_valid, n_out_valid;
    uuidtp_pkg::t_result r_out,       n_out;

    logic w_slot_free;
    logic w_do_body;
    logic w_dash_slot;
    logic w_ok;

    assign w_slot_free = !r_out_valid || i_pop;
    assign o_q_pop     = !i_q_empty && (!i_class.last || w_slot_free);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    assign w_dash_slot = (r_pos == uuidtp_pkg::DASH_POS0) || (r_pos == uuidtp_pkg::DASH_POS1)
                      || (r_pos == uuidtp_pkg::DASH_POS2) || (r_pos == uuidtp_pkg::DASH_POS3);

    always_comb begin
        n_phase  = r_phase;
        n_braced = r_braced;
        n_pos    = r_pos;
        n_odd    = r_odd;
        n_pend   = r_pend;
        n_id     = r_id;
        n_failed = r_failed;
        w_do_body = 1'b0;
        w_ok      = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;

        if (o_q_pop && !r_failed) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!i_class.is_space) begin
                        n_phase = PH_BODY;
                        if (i_class.is_open) begin
                            n_braced = 1'b1;
                        end else begin
                            w_do_body = 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_pos < uuidtp_pkg::BODY_LEN) begin
                        w_do_body = 1'b1;
                    end else if (r_braced ? i_class.is_close : i_class.is_space) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!i_class.is_space) begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase

            if (w_do_body) begin
                n_pos = r_pos + 6'd1;
                if (w_dash_slot) begin
                    if (!i_class.is_dash) begin
                        n_failed = 1'b1;
                    end
                end else if (!i_class.is_hex) begin
                    n_failed = 1'b1;
                end else if (!r_odd) begin
                    n_pend = i_class.hex_val;
                    n_odd  = 1'b1;
                end else begin
                    n_id  = {r_id[119:0], r_pend, i_class.hex_val};
                    n_odd = 1'b0;
                end
            end
        end

        if (o_q_pop && i_class.last) begin
            w_ok = !n_failed && ((n_phase == PH_TRAIL)
                || (n_phase == PH_BODY && !n_braced && n_pos == uuidtp_pkg::BODY_LEN));
            n_out_valid    = 1'b1;
            n_out.parse_ok = w_ok;
            n_out.id_upper = w_ok ? n_id[127:64] : 64'd0;
            n_out.id_lower = w_ok ? n_id[63:0]   : 64'd0;
            // start the next text from a clean slate
            n_phase  = PH_LEAD;
            n_braced = 1'b0;
            n_pos    = '0;
            n_odd    = 1'b0;
            n_pend   = '0;
            n_id     = '0;
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_braced    <= 1'b0;
            r_pos       <= '0;
            r_odd       <= 1'b0;
            r_pend      <= '0;
            r_id        <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_braced    <= n_braced;
            r_pos       <= n_pos;
            r_odd       <= n_odd;
            r_pend      <= n_pend;
            r_id        <= n_id;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
